/* design/mwo_pkg.sv */
// shared constants and tables of the mecanum wheel odometry block
package mwo_pkg;

  // bit-serial multiplier operand widths
  localparam int MulAW = 34;
  localparam int MulBW = 32;
  localparam int MulPW = MulAW + MulBW;

  // restoring divider widths
  localparam int DivNW = 64;
  localparam int DivDW = 52;

  // cordic datapath width and iteration count
  localparam int CorW = 36;
  localparam int CordicSteps = 30;

  // accumulator width for sums of products
  localparam int AccW = 68;

  // angle constants in Q30, plus the Q47 scale constant KQ47
  localparam logic [31:0] KQ47        = 32'd3598143388;
  localparam logic [33:0] PiQ30       = 34'd3373259426;
  localparam logic [33:0] HalfPiQ30   = 34'd1686629713;
  localparam logic [33:0] TwoPiQ30    = 34'd6746518852;
  localparam logic [33:0] CordicStart = 34'd652032874;

  // register reset values
  localparam logic [15:0] RadiusReset = 16'd2130;
  localparam logic [19:0] WbaseReset  = 20'd35389;
  localparam logic [15:0] PeriodReset = 16'd2621;

  // register indexes on the configuration port
  localparam logic [1:0] RegRadius = 2'd0;
  localparam logic [1:0] RegWbase  = 2'd1;
  localparam logic [1:0] RegPeriod = 2'd2;

  // atan(2^-i) in Q30, floored
  function automatic logic [CorW-1:0] atan_q30(input logic [4:0] i);
    logic [CorW-1:0] r;
    case (i)
      5'd0:  r = 36'd843314856;
      5'd1:  r = 36'd497837829;
      5'd2:  r = 36'd263043836;
      5'd3:  r = 36'd133525158;
      5'd4:  r = 36'd67021686;
      5'd5:  r = 36'd33543515;
      5'd6:  r = 36'd16775850;
      5'd7:  r = 36'd8388437;
      5'd8:  r = 36'd4194282;
      5'd9:  r = 36'd2097149;
      5'd10: r = 36'd1048575;
      5'd11: r = 36'd524287;
      5'd12: r = 36'd262143;
      5'd13: r = 36'd131071;
      5'd14: r = 36'd65535;
      5'd15: r = 36'd32767;
      5'd16: r = 36'd16383;
      5'd17: r = 36'd8191;
      5'd18: r = 36'd4095;
      5'd19: r = 36'd2047;
      5'd20: r = 36'd1023;
      5'd21: r = 36'd511;
      5'd22: r = 36'd255;
      5'd23: r = 36'd127;
      5'd24: r = 36'd63;
      5'd25: r = 36'd31;
      5'd26: r = 36'd15;
      5'd27: r = 36'd7;
      5'd28: r = 36'd3;
      5'd29: r = 36'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* design/mwo_intf.sv */
// valid/ready channel interfaces for encoder samples and pose results
interface mwo_in_if #(
  parameter int COUNT_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COUNT_WIDTH-1:0] front_left_count;
  logic signed [COUNT_WIDTH-1:0] front_right_count;
  logic signed [COUNT_WIDTH-1:0] rear_left_count;
  logic signed [COUNT_WIDTH-1:0] rear_right_count;

  modport source (
    output valid, front_left_count, front_right_count, rear_left_count, rear_right_count,
    input  ready
  );
  modport sink (
    input  valid, front_left_count, front_right_count, rear_left_count, rear_right_count,
    output ready
  );
endinterface

interface mwo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_position;
  logic signed [31:0] y_position;
  logic signed [31:0] heading_angle;
  logic signed [31:0] forward_travel;
  logic signed [31:0] sideways_travel;
  logic signed [31:0] turn_travel;

  modport source (
    output valid, x_position, y_position, heading_angle, forward_travel,
           sideways_travel, turn_travel,
    input  ready
  );
  modport sink (
    input  valid, x_position, y_position, heading_angle, forward_travel,
           sideways_travel, turn_travel,
    output ready
  );
endinterface

/* design/mwo_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
module mwo_mul import mwo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic             done_o,
  output logic [MulPW-1:0] prod_o
);

  logic             busy_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [MulAW-1:0] a_q;
  logic [MulBW-1:0] b_q;
  logic [MulPW-1:0] acc_q;
  logic [MulAW:0]   hi_sum;

  assign hi_sum = {1'b0, acc_q[MulPW-1:MulBW]} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(MulBW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= {hi_sum, acc_q[MulBW-1:1]};
      b_q   <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* design/mwo_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module mwo_div import mwo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DivDW-1:0] den_i,
  output logic             done_o,
  output logic [DivNW-1:0] quo_o,
  output logic [DivDW-1:0] rem_o
);

  logic             busy_q;
  logic             done_q;
  logic [5:0]       cnt_q;
  logic [DivNW-1:0] num_q;
  logic [DivDW-1:0] den_q;
  logic [DivDW-1:0] rem_q;
  logic [DivDW:0]   shifted;
  logic [DivDW+1:0] diff;
  logic             ge;

  assign shifted = {rem_q, num_q[DivNW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !diff[DivDW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DivNW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DivDW-1:0] : shifted[DivDW-1:0];
      num_q <= {num_q[DivNW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;
  assign rem_o  = rem_q;

endmodule

/* design/mwo_cordic.sv */
// rotation-mode cordic, one micro-rotation per cycle
module mwo_cordic import mwo_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [CorW-1:0] z_i,
  output logic                   done_o,
  output logic signed [CorW-1:0] x_o,
  output logic signed [CorW-1:0] y_o
);

  logic                   busy_q;
  logic                   done_q;
  logic [4:0]             i_q;
  logic signed [CorW-1:0] x_q;
  logic signed [CorW-1:0] y_q;
  logic signed [CorW-1:0] z_q;
  logic signed [CorW-1:0] xs;
  logic signed [CorW-1:0] ys;
  logic signed [CorW-1:0] at;

  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign at = $signed(atan_q30(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= $signed({2'b00, CordicStart});
      y_q <= '0;
      z_q <= z_i;
    end else if (busy_q) begin
      if (!z_q[CorW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

/* design/mecanum_wheel_odometry.sv */
// top level of the mecanum wheel odometry block: sequencer, registers and pose state
//
// use: an encoder sample (four signed wheel deltas) is one transfer on in_i, the
// updated pose and running travel sums come back as one transfer on out_o. the
// three scale registers sit on an apb-style port at byte addresses 0, 4 and 8 and
// are to be written only while the block is idle; the block does not enforce it.
// the block works on one sample at a time and in_i.ready is high only while the
// sequencer is idle. all products, quotients and rotations go through three shared
// serial units: a shift-add multiplier, a radix-2 divider and a cordic. a sample
// with a tiny turn needs 9 products, 2 divides and 1 cordic, one with a real turn
// 13 products, 5 divides and 2 cordics; that serial chain sets the rate.
// the result sits in the pose registers with out_o.valid high until taken; a new
// sample is accepted meanwhile and runs up to its final update, where it waits
// while the receiver stalls.
// reset clears pose and sums to zero and loads the default scale registers.
module mecanum_wheel_odometry import mwo_pkg::*; #(
  parameter int COUNT_WIDTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mwo_in_if.sink      in_i,
  mwo_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SumW = COUNT_WIDTH + 2;
  localparam int ShDs = 49 - FRACTION_BITS;
  localparam int ShTh = 32 - FRACTION_BITS;
  localparam int ShQ  = 30 - FRACTION_BITS;
  localparam int R0W  = 33 + ShQ + 2;
  localparam longint TurnEpsL = ((longint'(175) << FRACTION_BITS) + 500000) / 1000000;
  localparam logic [32:0] TurnEps = 33'(TurnEpsL);
  localparam logic signed [AccW-1:0] SatMax = AccW'(32'sh7FFF_FFFF);
  localparam logic signed [AccW-1:0] SatMin = AccW'(32'sh8000_0000);
  localparam logic signed [AccW-1:0] RndQ30 = AccW'(64'sd536870912);
  localparam logic signed [CorW-1:0] OneQ30 = CorW'(64'sd1073741824);
  localparam logic signed [CorW-1:0] PiC    = $signed({2'b00, PiQ30});
  localparam logic signed [CorW-1:0] HalfC  = $signed({2'b00, HalfPiQ30});

  // sequencer states
  typedef enum logic [17:0] {
    ST_IDLE = 18'b000000000000000001,
    ST_RP   = 18'b000000000000000010,
    ST_G    = 18'b000000000000000100,
    ST_DS   = 18'b000000000000001000,
    ST_DNS  = 18'b000000000000010000,
    ST_DTH0 = 18'b000000000000100000,
    ST_DTH1 = 18'b000000000001000000,
    ST_BR   = 18'b000000000010000000,
    ST_TR0  = 18'b000000000100000000,
    ST_TR1  = 18'b000000001000000000,
    ST_TR2  = 18'b000000010000000000,
    ST_TR3  = 18'b000000100000000000,
    ST_DOT0 = 18'b000001000000000000,
    ST_DOT1 = 18'b000010000000000000,
    ST_P0   = 18'b000100000000000000,
    ST_P1   = 18'b001000000000000000,
    ST_Q1   = 18'b010000000000000000,
    ST_UPD  = 18'b100000000000000000
  } state_e;

  // magnitude with sign, saturated to 32 bit signed
  function automatic logic signed [31:0] ssat(input logic [63:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
    end else begin
      r = (m >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end
    return r;
  endfunction

  // saturating 32 bit register update
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [AccW-1:0] d);
    logic signed [AccW-1:0] s;
    logic signed [31:0]     r;
    s = AccW'(a) + d;
    if (s > SatMax) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < SatMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  state_e state_q;

  // scale registers
  logic [15:0] radius_q;
  logic [19:0] wbase_q;
  logic [15:0] period_q;
  logic [19:0] lw;

  // pose and running sums, also the result payload
  logic signed [31:0] x_q, y_q, hd_q, fwd_q, side_q, turn_q;
  logic               out_valid_q;

  // per-sample working registers
  logic signed [SumW-1:0] sf_q, sn_q, st_q;
  logic [31:0]            g_q;
  logic signed [31:0]     ds_q, dns_q, dth_q, u_q, v_q;
  logic signed [32:0]     ang_q;
  logic                   r0neg_q;
  logic signed [CorW-1:0] red_q, sin_q, cos_q;
  logic                   fold_neg_q;
  logic                   trig_pass_q;
  logic                   rot_q;
  logic [1:0]             k_q;
  logic signed [AccW-1:0] acc0_q, acc1_q;

  // shared unit hookup
  logic                   mul_start, div_start, cor_start;
  logic [MulAW-1:0]       mul_a;
  logic [MulBW-1:0]       mul_b;
  logic                   mul_done;
  logic [MulPW-1:0]       mul_prod;
  logic [DivNW-1:0]       div_num, div_quo;
  logic [DivDW-1:0]       div_den, div_rem;
  logic                   div_done;
  logic signed [CorW-1:0] cor_z, cor_x, cor_y;
  logic                   cor_done;

  // combinational helpers
  logic                   in_xfer, out_xfer, upd_go;
  logic signed [SumW-1:0] sf_d, sn_d, st_d;
  logic [SumW-1:0]        sfm, snm, stm;
  logic [MulPW:0]         gsum;
  logic [31:0]            g_d;
  logic [MulPW:0]         rnd_sh;
  logic [32:0]            dthm;
  logic [DivDW-1:0]       den_arc;
  logic signed [R0W-1:0]  r0;
  logic [R0W-1:0]         r0m;
  logic [33:0]            remr, red_u;
  logic signed [CorW-1:0] fold_z;
  logic                   fold_n;
  logic [AccW-1:0]        acc0m, acc1m;
  logic signed [CorW-1:0] dot_a;
  logic signed [31:0]     dot_b;
  logic                   dot_neg;
  logic [CorW-1:0]        dot_am;
  logic [31:0]            dot_bm;
  logic                   dot_sign;
  logic signed [AccW-1:0] prod_s, term;
  logic signed [AccW-1:0] dx, dy;
  logic signed [32:0]     ang_mid;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_valid_q && out_o.ready;
  assign upd_go   = (state_q == ST_UPD) && (!out_valid_q || out_o.ready);

  assign lw = (wbase_q == '0) ? 20'd1 : wbase_q;

  // wheel count combinations, taken straight off the transfer
  assign sf_d = SumW'(in_i.front_left_count) + SumW'(in_i.front_right_count)
              + SumW'(in_i.rear_left_count) + SumW'(in_i.rear_right_count);
  assign sn_d = -SumW'(in_i.front_left_count) + SumW'(in_i.front_right_count)
              + SumW'(in_i.rear_left_count) - SumW'(in_i.rear_right_count);
  assign st_d = -SumW'(in_i.front_left_count) + SumW'(in_i.front_right_count)
              - SumW'(in_i.rear_left_count) + SumW'(in_i.rear_right_count);

  assign sfm = sf_q[SumW-1] ? -sf_q : sf_q;
  assign snm = sn_q[SumW-1] ? -sn_q : sn_q;
  assign stm = st_q[SumW-1] ? -st_q : st_q;

  // metres per count, rounded from the 64 bit product
  assign gsum = {1'b0, mul_prod} + (MulPW + 1)'(33'h0_8000_0000);
  assign g_d  = gsum[63:32];

  // round half up on the magnitude for the linear steps
  assign rnd_sh = ({1'b0, mul_prod} + ((MulPW + 1)'(1) << (ShDs - 1))) >> ShDs;

  assign dthm    = dth_q[31] ? -{dth_q[31], dth_q} : {1'b0, dth_q};
  assign den_arc = DivDW'(dthm) << ShQ;

  // angle to Q30 and shifted by pi ahead of the modulo
  assign r0  = (R0W'(ang_q) <<< ShQ) + $signed(R0W'(PiQ30));
  assign r0m = r0[R0W-1] ? -r0 : r0;

  // remainder back into [0, 2pi) for negative angles
  assign remr  = div_rem[33:0];
  assign red_u = (r0neg_q && (remr != '0)) ? (TwoPiQ30 - remr) : remr;

  // fold into [-pi/2, pi/2], results negated when folded
  always_comb begin
    fold_z = red_q;
    fold_n = 1'b0;
    if (red_q > HalfC) begin
      fold_z = red_q - PiC;
      fold_n = 1'b1;
    end else if (red_q < -HalfC) begin
      fold_z = red_q + PiC;
      fold_n = 1'b1;
    end
  end

  assign acc0m = acc0_q[AccW-1] ? -acc0_q : acc0_q;
  assign acc1m = acc1_q[AccW-1] ? -acc1_q : acc1_q;

  // product terms: arc numerators first, then the rotation into the world frame
  always_comb begin
    dot_a   = sin_q;
    dot_b   = ds_q;
    dot_neg = 1'b0;
    case ({rot_q, k_q})
      3'b000: begin
        dot_a = sin_q;
        dot_b = ds_q;
      end
      3'b001: begin
        dot_a = cos_q - OneQ30;
        dot_b = dns_q;
      end
      3'b010: begin
        dot_a = OneQ30 - cos_q;
        dot_b = ds_q;
      end
      3'b011: begin
        dot_a = sin_q;
        dot_b = dns_q;
      end
      3'b100: begin
        dot_a = cos_q;
        dot_b = u_q;
      end
      3'b101: begin
        dot_a   = sin_q;
        dot_b   = v_q;
        dot_neg = 1'b1;
      end
      3'b110: begin
        dot_a = sin_q;
        dot_b = u_q;
      end
      3'b111: begin
        dot_a = cos_q;
        dot_b = v_q;
      end
      default: begin
        dot_a = sin_q;
        dot_b = ds_q;
      end
    endcase
  end

  assign dot_am   = dot_a[CorW-1] ? -dot_a : dot_a;
  assign dot_bm   = dot_b[31] ? -dot_b : dot_b;
  assign dot_sign = dot_a[CorW-1] ^ dot_b[31] ^ dot_neg;
  assign prod_s   = $signed({2'b00, mul_prod});
  assign term     = dot_sign ? -prod_s : prod_s;

  assign dx      = (acc0_q + RndQ30) >>> 30;
  assign dy      = (acc1_q + RndQ30) >>> 30;
  assign ang_mid = {hd_q[31], hd_q} + {dth_q[31], dth_q[31], dth_q[31:1]};

  // shared unit requests
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    cor_start = 1'b0;
    cor_z     = fold_z;
    case (state_q)
      ST_IDLE: begin
        mul_start = in_xfer;
        mul_a     = MulAW'(radius_q);
        mul_b     = MulBW'(period_q);
      end
      ST_RP: begin
        mul_start = mul_done;
        mul_a     = MulAW'(mul_prod[31:0]);
        mul_b     = KQ47;
      end
      ST_G: begin
        mul_start = mul_done;
        mul_a     = MulAW'(sfm);
        mul_b     = g_d;
      end
      ST_DS: begin
        mul_start = mul_done;
        mul_a     = MulAW'(snm);
        mul_b     = g_q;
      end
      ST_DNS: begin
        mul_start = mul_done;
        mul_a     = MulAW'(stm);
        mul_b     = g_q;
      end
      ST_DTH0: begin
        div_start = mul_done;
        div_num   = DivNW'(mul_prod >> ShTh) + DivNW'(lw >> 1);
        div_den   = DivDW'(lw);
      end
      ST_TR0: begin
        div_start = 1'b1;
        div_num   = DivNW'(r0m);
        div_den   = DivDW'(TwoPiQ30);
      end
      ST_TR2: begin
        cor_start = 1'b1;
      end
      ST_DOT0: begin
        mul_start = 1'b1;
        mul_a     = MulAW'(dot_am);
        mul_b     = dot_bm;
      end
      ST_P0: begin
        div_start = 1'b1;
        div_num   = acc0m[DivNW-1:0] + DivNW'(den_arc >> 1);
        div_den   = den_arc;
      end
      ST_P1: begin
        div_start = div_done;
        div_num   = acc1m[DivNW-1:0] + DivNW'(den_arc >> 1);
        div_den   = den_arc;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      hd_q        <= '0;
      fwd_q       <= '0;
      side_q      <= '0;
      turn_q      <= '0;
      trig_pass_q <= 1'b0;
      rot_q       <= 1'b0;
      k_q         <= '0;
    end else begin
      if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_RP;
          end
        end
        ST_RP: begin
          if (mul_done) begin
            state_q <= ST_G;
          end
        end
        ST_G: begin
          if (mul_done) begin
            state_q <= ST_DS;
          end
        end
        ST_DS: begin
          if (mul_done) begin
            state_q <= ST_DNS;
          end
        end
        ST_DNS: begin
          if (mul_done) begin
            state_q <= ST_DTH0;
          end
        end
        ST_DTH0: begin
          if (mul_done) begin
            state_q <= ST_DTH1;
          end
        end
        ST_DTH1: begin
          if (div_done) begin
            state_q <= ST_BR;
          end
        end
        ST_BR: begin
          // tiny turn goes straight at the old heading
          trig_pass_q <= (dthm >= TurnEps);
          state_q     <= ST_TR0;
        end
        ST_TR0: begin
          state_q <= ST_TR1;
        end
        ST_TR1: begin
          if (div_done) begin
            state_q <= ST_TR2;
          end
        end
        ST_TR2: begin
          state_q <= ST_TR3;
        end
        ST_TR3: begin
          if (cor_done) begin
            rot_q   <= !trig_pass_q;
            k_q     <= '0;
            state_q <= ST_DOT0;
          end
        end
        ST_DOT0: begin
          state_q <= ST_DOT1;
        end
        ST_DOT1: begin
          if (mul_done) begin
            k_q <= k_q + 2'd1;
            if (k_q == 2'd3) begin
              state_q <= rot_q ? ST_UPD : ST_P0;
            end else begin
              state_q <= ST_DOT0;
            end
          end
        end
        ST_P0: begin
          state_q <= ST_P1;
        end
        ST_P1: begin
          if (div_done) begin
            state_q <= ST_Q1;
          end
        end
        ST_Q1: begin
          if (div_done) begin
            trig_pass_q <= 1'b0;
            state_q     <= ST_TR0;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            x_q         <= sat_add(x_q, dx);
            y_q         <= sat_add(y_q, dy);
            hd_q        <= sat_add(hd_q, AccW'(dth_q));
            fwd_q       <= sat_add(fwd_q, AccW'(ds_q));
            side_q      <= sat_add(side_q, AccW'(dns_q));
            turn_q      <= sat_add(turn_q, AccW'(dth_q));
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // working datapath registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sf_q <= sf_d;
      sn_q <= sn_d;
      st_q <= st_d;
    end
    if ((state_q == ST_G) && mul_done) begin
      g_q <= g_d;
    end
    if ((state_q == ST_DS) && mul_done) begin
      ds_q <= ssat(rnd_sh[63:0], sf_q[SumW-1]);
    end
    if ((state_q == ST_DNS) && mul_done) begin
      dns_q <= ssat(rnd_sh[63:0], sn_q[SumW-1]);
    end
    if ((state_q == ST_DTH1) && div_done) begin
      dth_q <= ssat(div_quo, st_q[SumW-1]);
    end
    if (state_q == ST_BR) begin
      if (dthm < TurnEps) begin
        ang_q <= {hd_q[31], hd_q};
        u_q   <= ds_q;
        v_q   <= dns_q;
      end else begin
        ang_q <= {dth_q[31], dth_q};
      end
    end
    if (state_q == ST_TR0) begin
      r0neg_q <= r0[R0W-1];
    end
    if ((state_q == ST_TR1) && div_done) begin
      red_q <= $signed({2'b00, red_u}) - PiC;
    end
    if (state_q == ST_TR2) begin
      fold_neg_q <= fold_n;
    end
    if ((state_q == ST_TR3) && cor_done) begin
      sin_q  <= fold_neg_q ? -cor_y : cor_y;
      cos_q  <= fold_neg_q ? -cor_x : cor_x;
      acc0_q <= '0;
      acc1_q <= '0;
    end
    if ((state_q == ST_DOT1) && mul_done) begin
      if (k_q[1]) begin
        acc1_q <= acc1_q + term;
      end else begin
        acc0_q <= acc0_q + term;
      end
    end
    if ((state_q == ST_P1) && div_done) begin
      u_q <= ssat(div_quo, acc0_q[AccW-1] != dth_q[31]);
    end
    if ((state_q == ST_Q1) && div_done) begin
      v_q   <= ssat(div_quo, acc1_q[AccW-1] != dth_q[31]);
      ang_q <= ang_mid;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadiusReset;
      wbase_q  <= WbaseReset;
      period_q <= PeriodReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegRadius: radius_q <= pwdata[15:0];
        RegWbase:  wbase_q  <= pwdata[19:0];
        RegPeriod: period_q <= pwdata[15:0];
        default:   radius_q <= radius_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegRadius: prdata = {16'b0, radius_q};
      RegWbase:  prdata = {12'b0, wbase_q};
      RegPeriod: prdata = {16'b0, period_q};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // channels
  assign in_i.ready            = (state_q == ST_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.x_position      = x_q;
  assign out_o.y_position      = y_q;
  assign out_o.heading_angle   = hd_q;
  assign out_o.forward_travel  = fwd_q;
  assign out_o.sideways_travel = side_q;
  assign out_o.turn_travel     = turn_q;

  mwo_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  mwo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  mwo_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z_i     (cor_z),
    .done_o  (cor_done),
    .x_o     (cor_x),
    .y_o     (cor_y)
  );

endmodule
